// File: design/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and constants of the gyro bias calibrator
// Widths, thresholds, register indexes and the item records that pass
// between the front pipeline, the queue and the calibration back end.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int CAL_WINDOW = 1000;

  localparam int RAW_W  = 16;
  localparam int PROD_W = 33;
  localparam int RATE_W = 20;
  localparam int DIF_W  = RATE_W + 1;
  localparam int R12_W  = 12;
  localparam int RSQ_W  = 21;
  localparam int ASQ_W  = 31;
  localparam int NORM_W = 33;
  localparam int BIAS_W = 12;

  localparam int CNT_W = $clog2(CAL_WINDOW + 1);
  localparam int SUM_W = $clog2(CAL_WINDOW + 1) + 12;
  localparam int DW    = 2 * $clog2(CAL_WINDOW + 1) + 23;
  localparam int QP_W  = 2 * SUM_W - 1;

  localparam int RATE_LIMIT = 512768;
  localparam int STILL_RATE = 1280;
  localparam logic [NORM_W-1:0] NORM_LO = 33'd13589544;
  localparam logic [NORM_W-1:0] NORM_HI = 33'd20300431;
  localparam logic [15:0] DPS_SCALE_RST = 16'd3996;

  localparam int RECIP_K = SUM_W - 1 + $clog2(CAL_WINDOW);
  localparam longint unsigned RECIP_M_L =
    ((64'd1 << RECIP_K) + 64'(CAL_WINDOW) - 64'd1) / 64'(CAL_WINDOW);
  localparam logic [SUM_W-1:0] RECIP_M = SUM_W'(RECIP_M_L);
  localparam logic signed [DW-1:0] VAR_THR =
    DW'((64'd65536 * 64'(CAL_WINDOW) * 64'(CAL_WINDOW)) / 64'd25);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic {
    REG_DPS_SCALE = 1'b0,
    REG_ROTATE    = 1'b1
  } cfg_reg_e;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic [RSQ_W-1:0]         rsq_t;
  typedef logic [ASQ_W-1:0]         asq_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DW-1:0]     dsum_t;
  typedef logic [QP_W-1:0]          qp_t;
  typedef logic signed [BIAS_W-1:0] bias_t;

  typedef struct packed {
    logic [15:0] dps_scale;
    logic        rotate;
  } cfg_t;

  typedef struct packed {
    logic             req;
    logic             still;
    rate_t [2:0]      rate;
    raw_t  [2:0]      accel;
    rsq_t  [2:0]      rsq;
  } qitem_t;

  typedef struct packed {
    logic        req;
    logic        still;
    logic        cal;
    logic        latch;
    sum_t  [2:0] sum;
    rate_t [2:0] rate;
    raw_t  [2:0] accel;
  } b1_t;

  typedef struct packed {
    logic        req;
    logic        still;
    logic        cal;
    logic        latch;
    logic  [2:0] neg;
    qp_t   [2:0] prod;
    rate_t [2:0] rate;
    raw_t  [2:0] accel;
  } b2_t;

endpackage

// File: design/gyro_still_bias_calibrator.sv
// Path: an accepted sample passes the front stages, the queue, the back-end stages b1
// and b2 and the output register; a calibration request produces no beat.
// Throughput: one beat per cycle unless the output stalls; the back end updates sums and
// the variance term for each taken still sample with one sum-by-rate multiply per axis.
// Reset: scale and rotation registers return to defaults, calibration state
// and bias are cleared, and all pipeline and queue entries are dropped at once.
// ----------------------------------------------------------------------------
// gyro_still_bias_calibrator: gyro bias calibration with stillness detection
// Front classifies samples, a short queue decouples it from the back end
// that accumulates, latches bias and emits corrected rates.
// ----------------------------------------------------------------------------
module gyro_still_bias_calibrator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_raw_x, accel_raw_y, accel_raw_z
  input  logic [95:0]   s_axis_tdata,
  // req_type
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // rate_x, rate_y, rate_z, accel_out_x, accel_out_y, accel_out_z, zero pad
  output logic [111:0]  m_axis_tdata,
  // is_calibrated, is_still
  output logic [1:0]    m_axis_tuser
);
  import gbc_pkg::*;

  cfg_t        cfg_q;
  raw_t [2:0]  gyro, accel;
  qitem_t      fq_item, bq_item;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  rate_t [2:0] rate;
  raw_t  [2:0] acc_out;
  logic        cal, still;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dps_scale <= DPS_SCALE_RST;
      cfg_q.rotate    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DPS_SCALE: cfg_q.dps_scale <= cfg_data_i;
        REG_ROTATE:    cfg_q.rotate    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gyro[i]  = s_axis_tdata[16*i +: 16];
      accel[i] = s_axis_tdata[48 + 16*i +: 16];
    end
  end

  gbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser[0]),
    .gyro_i      (gyro),
    .accel_i     (accel),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_item_o  (fq_item)
  );

  gbc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_item)
  );

  gbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (bq_valid),
    .in_ready_o   (bq_ready),
    .in_item_i    (bq_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .rate_o       (rate),
    .accel_o      (acc_out),
    .calibrated_o (cal),
    .still_o      (still)
  );

  assign m_axis_tdata = {4'b0, acc_out[2], acc_out[1], acc_out[0], rate[2], rate[1], rate[0]};
  assign m_axis_tuser = {still, cal};

endmodule

// File: design/gbc_front.sv
// ----------------------------------------------------------------------------
// gbc_front: scaling, alignment and stillness classification
// Three stages: rate multiply, shift/saturate/rotate with accel squares,
// norm and rate window test.
// ----------------------------------------------------------------------------
module gbc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gbc_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_req_i,
  input  gbc_pkg::raw_t [2:0]  gyro_i,
  input  gbc_pkg::raw_t [2:0]  accel_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gbc_pkg::qitem_t      out_item_o
);
  import gbc_pkg::*;

  logic f1_v_q, f2_v_q, f3_v_q;
  logic f1_adv, f2_adv, f3_adv;

  logic         f1_req_q;
  prod_t [2:0]  f1_prod_q;
  raw_t  [2:0]  f1_acc_q;

  logic         f2_req_q;
  rate_t [2:0]  f2_rate_q;
  raw_t  [2:0]  f2_acc_q;
  asq_t  [2:0]  f2_asq_q;

  qitem_t       f3_item_q;

  rate_t [2:0]  r_sc, r_al;
  raw_t  [2:0]  a_al;
  logic signed [2*RAW_W-1:0] a_sq [3];
  qitem_t       item_d;

  assign f3_adv     = !f3_v_q || out_ready_i;
  assign f2_adv     = !f2_v_q || f3_adv;
  assign f1_adv     = !f1_v_q || f2_adv;
  assign in_ready_o = f1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else begin
      if (f1_adv) f1_v_q <= in_valid_i;
      if (f2_adv) f2_v_q <= f1_v_q;
      if (f3_adv) f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_adv) begin
      f1_req_q <= in_req_i;
      f1_acc_q <= accel_i;
      for (int i = 0; i < 3; i++) begin
        f1_prod_q[i] <= gyro_i[i] * $signed({1'b0, cfg_i.dps_scale});
      end
    end
  end

  always_comb begin
    logic signed [PROD_W-9:0] q;
    for (int i = 0; i < 3; i++) begin
      q = f1_prod_q[i][PROD_W-1:8];
      if (q > (PROD_W-8)'(RATE_LIMIT)) begin
        r_sc[i] = RATE_W'(RATE_LIMIT);
      end else if (q < (PROD_W-8)'(-RATE_LIMIT)) begin
        r_sc[i] = RATE_W'(-RATE_LIMIT);
      end else begin
        r_sc[i] = q[RATE_W-1:0];
      end
    end
    if (cfg_i.rotate) begin
      r_al[0] = -r_sc[1];
      r_al[1] = r_sc[0];
      a_al[0] = (f1_acc_q[1] == 16'sh8000) ? 16'sh7FFF : -f1_acc_q[1];
      a_al[1] = f1_acc_q[0];
    end else begin
      r_al[0] = r_sc[0];
      r_al[1] = r_sc[1];
      a_al[0] = f1_acc_q[0];
      a_al[1] = f1_acc_q[1];
    end
    r_al[2] = r_sc[2];
    a_al[2] = f1_acc_q[2];
    for (int i = 0; i < 3; i++) begin
      a_sq[i] = a_al[i] * a_al[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f2_adv) begin
      f2_req_q  <= f1_req_q;
      f2_rate_q <= r_al;
      f2_acc_q  <= a_al;
      for (int i = 0; i < 3; i++) begin
        f2_asq_q[i] <= a_sq[i][ASQ_W-1:0];
      end
    end
  end

  always_comb begin
    logic [NORM_W-1:0]           norm;
    logic signed [R12_W-1:0]     r12;
    logic signed [2*R12_W-1:0]   r12sq;
    norm = NORM_W'(f2_asq_q[0]) + NORM_W'(f2_asq_q[1]) + NORM_W'(f2_asq_q[2]);
    item_d.req   = f2_req_q;
    item_d.rate  = f2_rate_q;
    item_d.accel = f2_acc_q;
    item_d.still = (norm > NORM_LO) && (norm <= NORM_HI);
    for (int i = 0; i < 3; i++) begin
      if (f2_rate_q[i] > RATE_W'(STILL_RATE) || f2_rate_q[i] < RATE_W'(-STILL_RATE)) begin
        item_d.still = 1'b0;
      end
      r12           = f2_rate_q[i][R12_W-1:0];
      r12sq         = r12 * r12;
      item_d.rsq[i] = r12sq[RSQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f3_adv) f3_item_q <= item_d;
  end

  assign out_valid_o = f3_v_q;
  assign out_item_o  = f3_item_q;

endmodule

// File: design/gbc_fifo.sv
// ----------------------------------------------------------------------------
// gbc_fifo: short item queue between front and back
// Small register queue; either side may stall on its own.
// ----------------------------------------------------------------------------
module gbc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  gbc_pkg::qitem_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output gbc_pkg::qitem_t pop_data_o
);
  import gbc_pkg::*;

  qitem_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (QPTR_W+1)'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// File: design/gbc_back.sv
// ----------------------------------------------------------------------------
// gbc_back: running sums, variance check, bias latch and correction
// Stage one updates calibration state, stage two forms the mean by
// reciprocal multiply, stage three applies bias into the output register.
// ----------------------------------------------------------------------------
module gbc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gbc_pkg::qitem_t      in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gbc_pkg::rate_t [2:0] rate_o,
  output gbc_pkg::raw_t  [2:0] accel_o,
  output logic                 calibrated_o,
  output logic                 still_o
);
  import gbc_pkg::*;

  logic b1_adv, b2_adv, b3_adv, take;
  logic b1_v_q, b2_v_q, out_v_q;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  sum_t  [2:0]      s_q, s_d, s_new;
  dsum_t [2:0]      d_q, d_d, d_new;
  logic             cal_q, cal_d;
  bias_t [2:0]      bias_q, bias_new, bias_use;

  b1_t  b1_d, b1_q;
  b2_t  b2_d, b2_q;

  rate_t [2:0] out_rate_d, out_rate_q;
  raw_t  [2:0] out_acc_q;
  logic        out_cal_q, out_still_q;

  assign b3_adv     = !out_v_q || out_ready_i;
  assign b2_adv     = !b2_v_q || b3_adv;
  assign b1_adv     = !b1_v_q || b2_adv;
  assign in_ready_o = b1_adv;
  assign take       = in_valid_i && b1_adv;

  always_comb begin
    logic signed [R12_W-1:0]       r12;
    logic signed [SUM_W+R12_W-1:0] sr;
    logic [RSQ_W+CNT_W-1:0]        nr;
    logic                          stable;
    logic                          last;
    stable = 1'b1;
    for (int i = 0; i < 3; i++) begin
      r12      = in_item_i.rate[i][R12_W-1:0];
      s_new[i] = s_q[i] + SUM_W'(r12);
      sr       = s_q[i] * r12;
      nr       = in_item_i.rsq[i] * CNT_W'(CAL_WINDOW - 1);
      d_new[i] = d_q[i] + $signed(DW'(nr)) - (DW'(sr) <<< 1);
      if (d_new[i] > VAR_THR) stable = 1'b0;
    end
    last = cnt_q == CNT_W'(CAL_WINDOW - 1);

    cnt_d      = cnt_q;
    s_d        = s_q;
    d_d        = d_q;
    cal_d      = cal_q;
    b1_d.latch = 1'b0;
    if (take) begin
      if (in_item_i.req) begin
        cnt_d = '0;
        s_d   = '0;
        d_d   = '0;
        cal_d = 1'b0;
      end else if (!cal_q) begin
        if (!in_item_i.still) begin
          cnt_d = '0;
          s_d   = '0;
          d_d   = '0;
        end else if (last) begin
          if (stable) begin
            cal_d      = 1'b1;
            b1_d.latch = 1'b1;
          end else begin
            cnt_d = '0;
            s_d   = '0;
            d_d   = '0;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
          s_d   = s_new;
          d_d   = d_new;
        end
      end
    end
    b1_d.req   = in_item_i.req;
    b1_d.still = in_item_i.still;
    b1_d.cal   = cal_d;
    b1_d.sum   = s_new;
    b1_d.rate  = in_item_i.rate;
    b1_d.accel = in_item_i.accel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      s_q   <= '0;
      d_q   <= '0;
      cal_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      s_q   <= s_d;
      d_q   <= d_d;
      cal_q <= cal_d;
    end
  end

  always_comb begin
    sum_t abs_s;
    b2_d.req   = b1_q.req;
    b2_d.still = b1_q.still;
    b2_d.cal   = b1_q.cal;
    b2_d.latch = b1_q.latch;
    b2_d.rate  = b1_q.rate;
    b2_d.accel = b1_q.accel;
    for (int i = 0; i < 3; i++) begin
      abs_s        = b1_q.sum[i][SUM_W-1] ? -b1_q.sum[i] : b1_q.sum[i];
      b2_d.neg[i]  = b1_q.sum[i][SUM_W-1];
      b2_d.prod[i] = abs_s[SUM_W-2:0] * RECIP_M;
    end
  end

  always_comb begin
    qp_t                    qv;
    logic signed [DIF_W-1:0] dif;
    for (int i = 0; i < 3; i++) begin
      qv          = b2_q.prod[i] >> RECIP_K;
      bias_new[i] = b2_q.neg[i] ? -$signed(qv[BIAS_W-1:0]) : $signed(qv[BIAS_W-1:0]);
      bias_use[i] = b2_q.latch ? bias_new[i] : bias_q[i];
      dif = DIF_W'(b2_q.rate[i]) - DIF_W'(bias_use[i]);
      if (dif > DIF_W'(RATE_LIMIT)) begin
        out_rate_d[i] = RATE_W'(RATE_LIMIT);
      end else if (dif < DIF_W'(-RATE_LIMIT)) begin
        out_rate_d[i] = RATE_W'(-RATE_LIMIT);
      end else begin
        out_rate_d[i] = dif[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      bias_q  <= '0;
    end else begin
      if (b1_adv) b1_v_q <= in_valid_i;
      if (b2_adv) b2_v_q <= b1_v_q;
      if (b3_adv) out_v_q <= b2_v_q && !b2_q.req;
      if (b3_adv && b2_v_q) begin
        if (b2_q.req) begin
          bias_q <= '0;
        end else if (b2_q.latch) begin
          bias_q <= bias_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_adv) b1_q <= b1_d;
    if (b2_adv) b2_q <= b2_d;
    if (b3_adv) begin
      out_rate_q  <= out_rate_d;
      out_acc_q   <= b2_q.accel;
      out_cal_q   <= b2_q.cal;
      out_still_q <= b2_q.still;
    end
  end

  assign out_valid_o  = out_v_q;
  assign rate_o       = out_rate_q;
  assign accel_o      = out_acc_q;
  assign calibrated_o = out_cal_q;
  assign still_o      = out_still_q;

endmodule
